// File: rtl/core/tbi_pkg.sv
// ============================================================================
// tbi_pkg - shared types and constants for the turtle branch interpreter
// Command and config types, register indexes, symbol codes, result kinds.
// ============================================================================
`default_nettype none

package tbi_pkg;

    // Stack of saved turtles
    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // Front-to-back command queue, power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Stream widths
    localparam int IN_W   = 16;
    localparam int OUT_W  = 128;
    localparam int USER_W = 2;

    // Config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_START_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_TURN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_TURN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y       = 3'd5;

    localparam logic [31:0]        START_LENGTH_RST  = 32'd6553600;
    localparam logic [15:0]        SHRINK_FACTOR_RST = 16'd49152;
    localparam logic signed [15:0] COS_TURN_RST      = 16'sd14849;
    localparam logic signed [15:0] SIN_TURN_RST      = 16'sd6924;
    localparam logic signed [31:0] START_X_RST       = 32'sd0;
    localparam logic signed [31:0] START_Y_RST       = -32'sd65536;
    localparam logic signed [15:0] HEADING_UP        = 16'sd16384;

    // Symbol codes
    localparam logic [7:0] SYM_DRAW  = 8'h46;  // F
    localparam logic [7:0] SYM_LEFT  = 8'h2A;  // *
    localparam logic [7:0] SYM_RIGHT = 8'h2F;  // /
    localparam logic [7:0] SYM_PUSH  = 8'h5B;  // [
    localparam logic [7:0] SYM_POP   = 8'h5D;  // ]

    // Result kinds
    localparam logic [USER_W-1:0] KIND_SEGMENT   = 2'd0;
    localparam logic [USER_W-1:0] KIND_OVERFLOW  = 2'd1;
    localparam logic [USER_W-1:0] KIND_UNDERFLOW = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DRAW,
        OP_TURN_L,
        OP_TURN_R,
        OP_PUSH,
        OP_POP
    } op_t;

    typedef struct packed {
        logic restart;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic [31:0]        start_length;
        logic [15:0]        shrink_factor;
        logic signed [15:0] cos_turn;
        logic signed [15:0] sin_turn;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
    } cfg_t;

    typedef struct packed {
        logic [USER_W-1:0]  kind;
        logic signed [31:0] x_from;
        logic signed [31:0] y_from;
        logic signed [31:0] x_to;
        logic signed [31:0] y_to;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/core/tbi_front.sv
// ============================================================================
// tbi_front - symbol decode stage
// Registers each item, turns its symbol into an op and drops items that
// neither restart nor do anything.
// ============================================================================
`default_nettype none

module tbi_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic         restart,
    input  wire logic [7:0]   symbol,
    output logic              cmd_valid,
    input  wire logic         cmd_ready,
    output tbi_pkg::cmd_t     cmd
);
    import tbi_pkg::*;

    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;
    op_t  op_dec;

    always_comb
    begin
        unique case (symbol)
            SYM_DRAW:  op_dec = OP_DRAW;
            SYM_LEFT:  op_dec = OP_TURN_L;
            SYM_RIGHT: op_dec = OP_TURN_R;
            SYM_PUSH:  op_dec = OP_PUSH;
            SYM_POP:   op_dec = OP_POP;
            default:   op_dec = OP_NONE;
        endcase
    end

    assign s_tready = !valid_reg || cmd_ready;

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (s_tvalid && s_tready)
        begin
            // plain ignored symbols leave no trace
            valid_next       = restart || (op_dec != OP_NONE);
            cmd_next.restart = restart;
            cmd_next.op      = op_dec;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

`default_nettype wire

// File: rtl/core/tbi_queue.sv
// ============================================================================
// tbi_queue - command queue between decode and execute
// Small FIFO so decode and execute stall independently.
// ============================================================================
`default_nettype none

module tbi_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  tbi_pkg::cmd_t     in_cmd,
    output logic              out_valid,
    input  wire logic         out_ready,
    output tbi_pkg::cmd_t     out_cmd
);
    import tbi_pkg::*;

    cmd_t              fifo_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = fifo_reg[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tbi_back.sv
// ============================================================================
// tbi_back - turtle execute unit
// Holds the turtle, the saved-turtle stack and the result register, and
// carries out one command per cycle, unless a draw waits on its products or a result stalls.
// ============================================================================
`default_nettype none

module tbi_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  tbi_pkg::cfg_t     cfg,
    input  wire logic         cmd_valid,
    output logic              cmd_ready,
    input  tbi_pkg::cmd_t     cmd,
    output logic              res_valid,
    input  wire logic         res_ready,
    output tbi_pkg::res_t     res
);
    import tbi_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] hx;
        logic signed [15:0] hy;
        logic [31:0]        len;
    } turtle_t;

    localparam turtle_t START_RST = '{
        x:   START_X_RST,
        y:   START_Y_RST,
        hx:  16'sd0,
        hy:  HEADING_UP,
        len: START_LENGTH_RST
    };

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111)
        begin
            r = v[31:0];
        end
        else
        begin
            r = v[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v[19:15] == 5'b00000 || v[19:15] == 5'b11111)
        begin
            r = v[15:0];
        end
        else
        begin
            r = v[19] ? 16'sh8000 : 16'sh7FFF;
        end
        return r;
    endfunction

    // Turtle and stack state
    turtle_t          cur_reg, cur_next;
    turtle_t          base_reg, base_next;     // stack entry 0
    turtle_t          top_reg, top_next;       // copy of the top entry
    logic             top_mem_reg, top_mem_next; // top sits in the read register
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Entries 1 and up; entry 0 lives in base_reg
    turtle_t          stack_mem [STACK_DEPTH];
    turtle_t          mem_q_reg;
    logic             rd_base_reg;
    logic             wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W-1:0] rd_idx;

    // length times heading, from the registered turtle
    logic signed [32:0] len_s;
    logic signed [48:0] prod_x_reg, prod_y_reg;
    logic               prod_ok_reg, prod_ok_next;

    logic res_valid_reg, res_valid_next;
    res_t res_reg, res_next;

    // Effective state after an optional restart
    turtle_t          start_t;
    turtle_t          act;
    turtle_t          top_act;
    logic [CNT_W-1:0] cnt_act;
    logic             full;
    logic             empty;

    // Draw datapath
    logic signed [48:0] rnd_x, rnd_y;
    logic signed [34:0] dx, dy;
    logic signed [35:0] sum_x, sum_y;
    logic signed [31:0] new_x, new_y;

    // Turn datapath
    logic signed [16:0] s17, s_eff;
    logic signed [32:0] p_chx, p_chy, p_shx, p_shy;
    logic signed [33:0] rot_x, rot_y;
    logic signed [33:0] rnd_rx, rnd_ry;
    logic signed [15:0] new_hx, new_hy;

    // Push datapath
    logic [47:0] shr_prod;
    logic [47:0] shr_rnd;

    logic need_res;
    logic draw_wait;
    logic fire;

    always_comb
    begin
        start_t = '{
            x:   cfg.start_x,
            y:   cfg.start_y,
            hx:  16'sd0,
            hy:  HEADING_UP,
            len: cfg.start_length
        };
        act     = cmd.restart ? start_t : cur_reg;
        cnt_act = cmd.restart ? CNT_W'(1) : cnt_reg;
        if (cmd.restart)
        begin
            top_act = start_t;
        end
        else if (top_mem_reg)
        begin
            top_act = rd_base_reg ? base_reg : mem_q_reg;
        end
        else
        begin
            top_act = top_reg;
        end
        full  = (cnt_act == CNT_W'(STACK_DEPTH));
        empty = (cnt_act == '0);
    end

    // Draw: delta = round(len * heading / 2^14); restart heading is straight up
    always_comb
    begin
        rnd_x = prod_x_reg + 49'sd8192;
        rnd_y = prod_y_reg + 49'sd8192;
        if (cmd.restart)
        begin
            dx = '0;
            dy = {3'b000, cfg.start_length};
        end
        else
        begin
            dx = rnd_x[48:14];
            dy = rnd_y[48:14];
        end
        sum_x = {{4{act.x[31]}}, act.x} + {dx[34], dx};
        sum_y = {{4{act.y[31]}}, act.y} + {dy[34], dy};
        new_x = sat32(sum_x);
        new_y = sat32(sum_y);
    end

    // Turn: rotate heading by (cos, +-sin), round half up, saturate
    always_comb
    begin
        s17    = {cfg.sin_turn[15], cfg.sin_turn};
        s_eff  = (cmd.op == OP_TURN_R) ? (17'sd0 - s17) : s17;
        p_chx  = cfg.cos_turn * act.hx;
        p_chy  = cfg.cos_turn * act.hy;
        p_shx  = s_eff * act.hx;
        p_shy  = s_eff * act.hy;
        rot_x  = {p_chx[32], p_chx} - {p_shy[32], p_shy};
        rot_y  = {p_shx[32], p_shx} + {p_chy[32], p_chy};
        rnd_rx = rot_x + 34'sd8192;
        rnd_ry = rot_y + 34'sd8192;
        new_hx = sat16(rnd_rx[33:14]);
        new_hy = sat16(rnd_ry[33:14]);
    end

    // Push: len * shrink / 2^16, round half up
    always_comb
    begin
        shr_prod = act.len * cfg.shrink_factor;
        shr_rnd  = shr_prod + 48'd32768;
    end

    always_comb
    begin
        need_res  = (cmd.op == OP_DRAW) || ((cmd.op == OP_PUSH) && full) ||
                    ((cmd.op == OP_POP) && empty);
        draw_wait = (cmd.op == OP_DRAW) && !cmd.restart && !prod_ok_reg;
        cmd_ready = !draw_wait && !(need_res && res_valid_reg && !res_ready);
        fire      = cmd_valid && cmd_ready;
    end

    always_comb
    begin
        cur_next       = cur_reg;
        base_next      = base_reg;
        top_next       = top_reg;
        top_mem_next   = top_mem_reg;
        cnt_next       = cnt_reg;
        prod_ok_next   = 1'b1;
        wr_en          = 1'b0;
        wr_addr        = cnt_act[ADDR_W-1:0];
        rd_en          = 1'b0;
        rd_idx         = cnt_act - CNT_W'(2);
        rd_addr        = rd_idx[ADDR_W-1:0];
        res_valid_next = res_ready ? 1'b0 : res_valid_reg;
        res_next       = res_reg;

        if (fire)
        begin
            if (cmd.restart)
            begin
                cur_next     = start_t;
                cnt_next     = CNT_W'(1);
                base_next    = start_t;
                top_next     = start_t;
                top_mem_next = 1'b0;
                prod_ok_next = 1'b0;
            end

            unique case (cmd.op)
                OP_DRAW:
                begin
                    cur_next.x     = new_x;
                    cur_next.y     = new_y;
                    res_valid_next = 1'b1;
                    res_next       = '{KIND_SEGMENT, act.x, act.y, new_x, new_y};
                end
                OP_TURN_L, OP_TURN_R:
                begin
                    cur_next.hx  = new_hx;
                    cur_next.hy  = new_hy;
                    prod_ok_next = 1'b0;
                end
                OP_PUSH:
                begin
                    if (full)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '{KIND_OVERFLOW, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
                    end
                    else
                    begin
                        if (empty)
                        begin
                            base_next = act;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                        end
                        top_next     = act;
                        top_mem_next = 1'b0;
                        cnt_next     = cnt_act + 1'b1;
                        cur_next.len = shr_rnd[47:16];
                        prod_ok_next = 1'b0;
                    end
                end
                OP_POP:
                begin
                    if (empty)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '{KIND_UNDERFLOW, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
                    end
                    else
                    begin
                        cur_next     = top_act;
                        cnt_next     = cnt_act - 1'b1;
                        prod_ok_next = 1'b0;
                        // prefetch the entry that becomes the new top
                        if (cnt_act >= CNT_W'(2))
                        begin
                            rd_en        = 1'b1;
                            top_mem_next = 1'b1;
                        end
                        else
                        begin
                            top_mem_next = 1'b0;
                        end
                    end
                end
                OP_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= START_RST;
            base_reg      <= START_RST;
            top_reg       <= START_RST;
            top_mem_reg   <= 1'b0;
            cnt_reg       <= CNT_W'(1);
            prod_ok_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            base_reg      <= base_next;
            top_reg       <= top_next;
            top_mem_reg   <= top_mem_next;
            cnt_reg       <= cnt_next;
            prod_ok_reg   <= prod_ok_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign len_s = {1'b0, cur_reg.len};

    always_ff @(posedge clk)
    begin
        prod_x_reg <= len_s * cur_reg.hx;
        prod_y_reg <= len_s * cur_reg.hy;
        res_reg    <= res_next;
    end

    // Stack memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= act;
        end
        if (rd_en)
        begin
            mem_q_reg   <= stack_mem[rd_addr];
            rd_base_reg <= (rd_addr == '0);
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// File: rtl/core/turtle_branch_interpreter_top.sv
// ============================================================================
// turtle_branch_interpreter_top - 2D L-system turtle interpreter
// Streams symbols in, streams line segments and stack faults out.
// ============================================================================
// One symbol per input item: F draws, * turns left, / turns right, [ pushes
// the turtle and shrinks the step length, ] pops it; other symbols are
// dropped. A set restart bit reloads the start state (and makes it the only
// stack entry) before the symbol acts. Each item is decoded in a register
// stage, waits in a four-entry command queue, and is executed by the back
// unit, which owns the turtle, the 64-entry stack and the result register.
// Throughput is one item per cycle, with two exceptions. The first is a draw
// that directly follows an item which changed heading or length (turn, push,
// pop or restart): it waits until the length-times-heading products, which
// come from a register fed by the current turtle, are renewed. A draw carrying
// its own restart bit needs no product and does not wait. An item that
// makes a result (a draw, or a push or pop that faults) also waits while
// the result register still holds an item the receiver has not taken.
// Pushes and pops run back to back: the top entry is kept in a register
// and the entry below it is prefetched through the stack memory's
// registered read port. Stack entries need no clearing after reset. Config
// writes must only happen while the block is idle.
// ============================================================================
`default_nettype none

module turtle_branch_interpreter_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [tbi_pkg::IN_W-1:0]        s_tdata,   // restart, symbol[7:0], zero pad
    // result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [tbi_pkg::OUT_W-1:0]            m_tdata,   // x_from, y_from, x_to, y_to
    output logic [tbi_pkg::USER_W-1:0]           m_tuser,   // kind
    // config writes
    input  wire logic                            cfg_we,
    input  wire logic [tbi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tbi_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tbi_pkg::*;

    cfg_t cfg_reg, cfg_next;

    // front -> queue
    logic f_valid;
    logic f_ready;
    cmd_t f_cmd;

    // queue -> back
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    res_t res;

    // Config registers; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_LENGTH:  cfg_next.start_length  = cfg_data;
                CFG_SHRINK_FACTOR: cfg_next.shrink_factor = cfg_data[15:0];
                CFG_COS_TURN:      cfg_next.cos_turn      = cfg_data[15:0];
                CFG_SIN_TURN:      cfg_next.sin_turn      = cfg_data[15:0];
                CFG_START_X:       cfg_next.start_x       = cfg_data;
                CFG_START_Y:       cfg_next.start_y       = cfg_data;
                default:           cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{
                start_length:  START_LENGTH_RST,
                shrink_factor: SHRINK_FACTOR_RST,
                cos_turn:      COS_TURN_RST,
                sin_turn:      SIN_TURN_RST,
                start_x:       START_X_RST,
                start_y:       START_Y_RST
            };
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Decode
    tbi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .restart   (s_tdata[0]),
        .symbol    (s_tdata[8:1]),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    // Decouple decode from execute
    tbi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    // Execute; holds the output register
    tbi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {res.y_to, res.x_to, res.y_from, res.x_from};
    assign m_tuser = res.kind;

endmodule

`default_nettype wire

// File: rtl/core/tbi_checker.sv
// ============================================================================
// tbi_checker - port-level assertions for the turtle interpreter
// Watches the result stream of the top level.
// ============================================================================
`default_nettype none

module tbi_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [tbi_pkg::OUT_W-1:0]     m_tdata,
    input wire logic [tbi_pkg::USER_W-1:0]    m_tuser
);
    import tbi_pkg::*;

    // stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // stack faults carry no coordinates
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_OVERFLOW || m_tuser == KIND_UNDERFLOW)
        |-> m_tdata == '0)
        else $error("fault result with nonzero coordinates");

    // nothing comes out while in reset; valid may still be unknown at the
    // first edge, before the reset has taken hold
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> m_tvalid !== 1'b1)
        else $error("result valid during reset");

    // no result right after reset is released
    a_reset_release: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind turtle_branch_interpreter_top tbi_checker u_tbi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
